### rtl/ldf_pkg.sv
// ----------------------------------------------------------------------------
// ldf_pkg
// Shared types and constants for the length-prefix deframer.
// ----------------------------------------------------------------------------
package ldf_pkg;

    // Octets in the big-endian length prefix (1 to 4).
    localparam int PREFIX_BYTES = 2;
    localparam int PCNT_W       = $clog2(PREFIX_BYTES + 1);
    localparam logic [PCNT_W-1:0] PCNT_LAST = PCNT_W'(PREFIX_BYTES - 1);

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 16;
    // One extra bit holds the saturated value 65536.
    localparam int ACC_W  = LEN_W + 1;
    localparam logic [ACC_W-1:0] LEN_CAP = {1'b1, {LEN_W{1'b0}}};

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_OCTETS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_OCTETS = 1'b1;

    localparam logic [LEN_W-1:0] MIN_OCTETS_RST = 16'd12;
    localparam logic [LEN_W-1:0] MAX_OCTETS_RST = 16'hFFFF;

    typedef enum logic [2:0] {
        PH_PREFIX = 3'b001,
        PH_BODY   = 3'b010,
        PH_FAILED = 3'b100
    } phase_t;

    typedef struct packed {
        logic [LEN_W-1:0] min_octets;
        logic [LEN_W-1:0] max_octets;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic [LEN_W-1:0]  message_length;
        logic              last_of_message;
        logic              malformed_error;
    } result_t;

endpackage

### rtl/ldf_cfg_regs.sv
// ----------------------------------------------------------------------------
// ldf_cfg_regs
// Minimum and maximum message length registers with their write channel.
// ----------------------------------------------------------------------------
module ldf_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ldf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ldf_pkg::LEN_W-1:0]     cfg_data,
    output ldf_pkg::cfg_t                 cfg
);
    import ldf_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_MIN_OCTETS: cfg_next.min_octets = cfg_data;
                REG_MAX_OCTETS: cfg_next.max_octets = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_octets <= MIN_OCTETS_RST;
            cfg_reg.max_octets <= MAX_OCTETS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### rtl/ldf_parser.sv
// ----------------------------------------------------------------------------
// ldf_parser
// Framing state: prefix collection, length check, body count and failure.
// ----------------------------------------------------------------------------
module ldf_parser (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       step,
    input  logic [ldf_pkg::BYTE_W-1:0] in_byte,
    input  ldf_pkg::cfg_t              cfg,
    output logic                       has_result,
    output ldf_pkg::result_t           result
);
    import ldf_pkg::*;

    phase_t            phase_reg,    phase_next;
    logic [PCNT_W-1:0] pcnt_reg,     pcnt_next;
    logic [ACC_W-1:0]  acc_reg,      acc_next;
    logic [LEN_W-1:0]  decl_len_reg, decl_len_next;
    logic [LEN_W-1:0]  left_reg,     left_next;

    logic [ACC_W-1:0]  acc_shift;
    logic              len_bad;
    logic              body_last;

    // Shifting in another octet overflows 16 bits once the accumulator
    // already holds more than one octet's worth; clamp to the cap then.
    assign acc_shift = (acc_reg[ACC_W-1:BYTE_W] != '0) ? LEN_CAP
                     : {acc_reg[ACC_W-BYTE_W-1:0], in_byte};
    assign len_bad   = (acc_shift < {1'b0, cfg.min_octets})
                    || (acc_shift > {1'b0, cfg.max_octets});
    assign body_last = (left_reg <= LEN_W'(1));

    always_comb begin
        phase_next    = phase_reg;
        pcnt_next     = pcnt_reg;
        acc_next      = acc_reg;
        decl_len_next = decl_len_reg;
        left_next     = left_reg;
        has_result    = 1'b0;
        result        = '0;

        unique case (phase_reg)
            PH_FAILED: begin
                has_result = 1'b0;
            end
            PH_BODY: begin
                has_result             = 1'b1;
                result.payload_byte    = in_byte;
                result.message_length  = decl_len_reg;
                result.last_of_message = body_last;
                if (body_last) begin
                    left_next  = '0;
                    phase_next = PH_PREFIX;
                end else begin
                    left_next = left_reg - LEN_W'(1);
                end
            end
            default: begin
                // Prefix phase; an unused code behaves the same way.
                phase_next = PH_PREFIX;
                acc_next   = acc_shift;
                pcnt_next  = pcnt_reg + PCNT_W'(1);
                if (pcnt_reg == PCNT_LAST) begin
                    pcnt_next = '0;
                    acc_next  = '0;
                    if (len_bad) begin
                        decl_len_next = acc_shift[LEN_W] ? {LEN_W{1'b1}}
                                                         : acc_shift[LEN_W-1:0];
                        phase_next             = PH_FAILED;
                        has_result             = 1'b1;
                        result.message_length  = decl_len_next;
                        result.malformed_error = 1'b1;
                    end else begin
                        decl_len_next = acc_shift[LEN_W-1:0];
                        left_next     = acc_shift[LEN_W-1:0];
                        phase_next    = (acc_shift == '0) ? PH_PREFIX : PH_BODY;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_PREFIX;
            pcnt_reg     <= '0;
            acc_reg      <= '0;
            decl_len_reg <= '0;
            left_reg     <= '0;
        end else if (step) begin
            phase_reg    <= phase_next;
            pcnt_reg     <= pcnt_next;
            acc_reg      <= acc_next;
            decl_len_reg <= decl_len_next;
            left_reg     <= left_next;
        end
    end

endmodule

### rtl/ldf_out_stage.sv
// ----------------------------------------------------------------------------
// ldf_out_stage
// Result register driving the result channel.
// ----------------------------------------------------------------------------
module ldf_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  ldf_pkg::result_t result,
    output logic             out_free,
    output logic             m_valid,
    input  logic             m_ready,
    output ldf_pkg::result_t m_result
);
    import ldf_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // The register can take a new result when empty or when its current
    // result is transferred in this cycle.
    assign out_free   = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);
    assign m_valid    = valid_reg;
    assign m_result   = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

endmodule

### rtl/length_prefix_deframer_core.sv
// ----------------------------------------------------------------------------
// length_prefix_deframer_core
// Splits a byte stream into messages framed by a big-endian length prefix.
// ----------------------------------------------------------------------------
// Usage: bytes enter on s_stream_byte, one per transfer. Prefix bytes give
// no result; each body byte leaves on the m_ channel with the message
// length and a last-of-message flag. A length outside the configured
// minimum and maximum gives one result with m_malformed_error set, after
// which every byte is dropped until reset.
// The cfg_ channel writes the minimum (index 0) and maximum (index 1);
// writes are always accepted and should be made while the block is idle.
// Each accepted byte passes the input register, then the result register, on
// its way to m_. Throughput is one byte per cycle while m_ready stays high.
// When m_ready is low the result is held; the input register still drains
// bytes that give no result and stalls s_ready once a byte with a result
// has to wait. Reset clears the framing state, empties both registers and
// restores minimum 12 and maximum 65535.
// ----------------------------------------------------------------------------
module length_prefix_deframer_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ldf_pkg::BYTE_W-1:0]    s_stream_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ldf_pkg::BYTE_W-1:0]    m_payload_byte,
    output logic [ldf_pkg::LEN_W-1:0]     m_message_length,
    output logic                          m_last_of_message,
    output logic                          m_malformed_error,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ldf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ldf_pkg::LEN_W-1:0]     cfg_data
);
    import ldf_pkg::*;

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              s_xfer;
    logic              advance;
    logic              has_result;
    logic              out_free;
    cfg_t              cfg;
    result_t           result;
    result_t           m_result;

    assign advance       = in_valid_reg && (!has_result || out_free);
    assign s_ready       = !in_valid_reg || advance;
    assign s_xfer        = s_valid && s_ready;
    assign in_valid_next = s_xfer || (in_valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_byte_reg <= s_stream_byte;
        end
    end

    ldf_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ldf_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .in_byte    (in_byte_reg),
        .cfg        (cfg),
        .has_result (has_result),
        .result     (result)
    );

    ldf_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && has_result),
        .result   (result),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_payload_byte    = m_result.payload_byte;
    assign m_message_length  = m_result.message_length;
    assign m_last_of_message = m_result.last_of_message;
    assign m_malformed_error = m_result.malformed_error;

endmodule

### test/length_prefix_deframer_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefix_deframer_core_test
// Self-checking bench: framed byte streams against a cycle-free predictor.
// ----------------------------------------------------------------------------
// A short directed table covers minimum-length and zero-length messages and
// extreme byte values. Random phases then run well-formed messages under
// several length limits. The run ends by provoking the one malformed-length
// report, since that failure is sticky, and by checking that later bytes are
// dropped. Both channels idle at random, except for one phase that runs
// without gaps.
// ----------------------------------------------------------------------------
module length_prefix_deframer_core_test;
    import ldf_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 850;
    localparam int PHASE_ITEMS = 170;

    typedef enum {ROW_BYTE, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   index;
        logic [LEN_W-1:0]       data;
        bit                     typed;
        bit                     gives;
        result_t                want;
    } stim_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [BYTE_W-1:0]      s_stream_byte = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [BYTE_W-1:0]      m_payload_byte;
    logic [LEN_W-1:0]       m_message_length;
    logic                   m_last_of_message;
    logic                   m_malformed_error;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = REG_MIN_OCTETS;
    logic [LEN_W-1:0]       cfg_data = '0;

    // Predictor state and its copy of the length limits.
    phase_t                 frm_phase = PH_PREFIX;
    logic [LEN_W-1:0]       frm_len = '0;
    logic [LEN_W-1:0]       frm_left = '0;
    logic [ACC_W-1:0]       frm_accum = '0;
    int                     frm_pcnt = 0;
    logic [LEN_W-1:0]       lim_min = MIN_OCTETS_RST;
    logic [LEN_W-1:0]       lim_max = MAX_OCTETS_RST;

    result_t                due_results[$];
    int                     bad_count = 0;
    int                     cycle_count = 0;
    bit                     steady_flow = 1'b0;

    stim_row_t directed_rows[25] = '{
        '{ROW_BYTE, REG_MIN_OCTETS, 16'h00, 1'b1, 1'b0, '0},
        '{ROW_BYTE, REG_MIN_OCTETS, 16'h0C, 1'b1, 1'b0, '0},
        '{ROW_BYTE, REG_MIN_OCTETS, 16'h00, 1'b1, 1'b1, {8'h00, 16'd12, 1'b0, 1'b0}},
        '{ROW_BYTE, REG_MIN_OCTETS, 16'hFF, 1'b1, 1'b1, {8'hFF, 16'd12, 1'b0, 1'b0}},
        '{ROW_BYTE, REG_MIN_OCTETS, 16'h01, 1'b1, 1'b1, {8'h01, 16'd12, 1'b0, 1'b0}},
        '{ROW_BYTE, REG_MIN_OCTETS, 16'h80, 1'b1, 1'b1, {8'h80, 16'd12, 1'b0, 1'b0}},
        '{ROW_BYTE, REG_MIN_OCTETS, 16'h7F, 1'b1, 1'b1, {8'h7F, 16'd12, 1'b0, 1'b0}},
        '{ROW_BYTE, REG_MIN_OCTETS, 16'hFE, 1'b1, 1'b1, {8'hFE, 16'd12, 1'b0, 1'b0}},
        '{ROW_BYTE, REG_MIN_OCTETS, 16'h55, 1'b1, 1'b1, {8'h55, 16'd12, 1'b0, 1'b0}},
        '{ROW_BYTE, REG_MIN_OCTETS, 16'hAA, 1'b1, 1'b1, {8'hAA, 16'd12, 1'b0, 1'b0}},
        '{ROW_BYTE, REG_MIN_OCTETS, 16'h0F, 1'b1, 1'b1, {8'h0F, 16'd12, 1'b0, 1'b0}},
        '{ROW_BYTE, REG_MIN_OCTETS, 16'hF0, 1'b1, 1'b1, {8'hF0, 16'd12, 1'b0, 1'b0}},
        '{ROW_BYTE, REG_MIN_OCTETS, 16'h3C, 1'b1, 1'b1, {8'h3C, 16'd12, 1'b0, 1'b0}},
        '{ROW_BYTE, REG_MIN_OCTETS, 16'hC3, 1'b1, 1'b1, {8'hC3, 16'd12, 1'b1, 1'b0}},
        // With the minimum at zero, an empty message gives nothing.
        '{ROW_CFG,  REG_MIN_OCTETS, 16'd0,  1'b0, 1'b0, '0},
        '{ROW_BYTE, REG_MIN_OCTETS, 16'h00, 1'b1, 1'b0, '0},
        '{ROW_BYTE, REG_MIN_OCTETS, 16'h00, 1'b1, 1'b0, '0},
        '{ROW_BYTE, REG_MIN_OCTETS, 16'h00, 1'b1, 1'b0, '0},
        '{ROW_BYTE, REG_MIN_OCTETS, 16'h01, 1'b1, 1'b0, '0},
        '{ROW_BYTE, REG_MIN_OCTETS, 16'hA5, 1'b1, 1'b1, {8'hA5, 16'd1, 1'b1, 1'b0}},
        '{ROW_CFG,  REG_MAX_OCTETS, 16'd2,  1'b0, 1'b0, '0},
        '{ROW_BYTE, REG_MIN_OCTETS, 16'h00, 1'b0, 1'b0, '0},
        '{ROW_BYTE, REG_MIN_OCTETS, 16'h02, 1'b0, 1'b0, '0},
        '{ROW_BYTE, REG_MIN_OCTETS, 16'h5A, 1'b0, 1'b0, '0},
        '{ROW_BYTE, REG_MIN_OCTETS, 16'hC3, 1'b0, 1'b0, '0}
    };

    length_prefix_deframer_core dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_stream_byte     (s_stream_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_payload_byte    (m_payload_byte),
        .m_message_length  (m_message_length),
        .m_last_of_message (m_last_of_message),
        .m_malformed_error (m_malformed_error),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready <= steady_flow || ($urandom_range(99) >= 19);
    end

    function automatic void due_add(input result_t r);
        due_results.insert(due_results.size(), r);
    endfunction

    function automatic result_t due_take();
        result_t r;
        r = due_results[0];
        due_results.delete(0);
        return r;
    endfunction

    // Advances the framing state by one byte; returns 1 when a result is due.
    function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output result_t res);
        logic [31:0] acc_next;
        bit          last;
        bit          gives;
        res = '0;
        gives = 1'b0;
        case (frm_phase)
            PH_FAILED: gives = 1'b0;
            PH_BODY: begin
                last = (frm_left <= 1);
                res.payload_byte = b;
                res.message_length = frm_len;
                res.last_of_message = last;
                gives = 1'b1;
                if (last) begin
                    frm_left = '0;
                    frm_phase = PH_PREFIX;
                end else begin
                    frm_left = frm_left - 1'b1;
                end
            end
            default: begin
                frm_phase = PH_PREFIX;
                // The accumulator saturates one above the largest 16-bit length.
                acc_next = (32'(frm_accum) << 8) | 32'(b);
                if (acc_next > 32'(LEN_CAP)) begin
                    acc_next = 32'(LEN_CAP);
                end
                frm_accum = acc_next[ACC_W-1:0];
                frm_pcnt++;
                if (frm_pcnt >= PREFIX_BYTES) begin
                    frm_pcnt = 0;
                    frm_accum = '0;
                    if (acc_next < lim_min || acc_next > lim_max) begin
                        frm_len = (acc_next > 32'hFFFF) ? 16'hFFFF : acc_next[LEN_W-1:0];
                        frm_phase = PH_FAILED;
                        res.message_length = frm_len;
                        res.malformed_error = 1'b1;
                        gives = 1'b1;
                    end else begin
                        frm_len = acc_next[LEN_W-1:0];
                        frm_left = acc_next[LEN_W-1:0];
                        if (acc_next == 0) begin
                            frm_phase = PH_PREFIX;
                        end else begin
                            frm_phase = PH_BODY;
                        end
                    end
                end
            end
        endcase
        return gives;
    endfunction

    function automatic void report_mismatch(input string what, input result_t want,
                                            input result_t got);
        bad_count++;
        if (bad_count <= 10) begin
            $display({"%0t %s: want byte %h len %0d last %b err %b, ",
                      "got byte %h len %0d last %b err %b"},
                     $realtime, what, want.payload_byte, want.message_length,
                     want.last_of_message, want.malformed_error, got.payload_byte,
                     got.message_length, got.last_of_message, got.malformed_error);
        end
    endfunction

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_payload_byte, m_message_length, m_last_of_message, m_malformed_error};
            if (due_results.size() == 0) begin
                report_mismatch("result with nothing due", '0, got);
            end else begin
                want = due_take();
                if (got.payload_byte !== want.payload_byte
                        || got.message_length !== want.message_length
                        || got.last_of_message !== want.last_of_message
                        || got.malformed_error !== want.malformed_error) begin
                    report_mismatch("result mismatch", want, got);
                end
            end
        end
    end

    // A typed row supplies its own expectation; the predictor still tracks state.
    task automatic push_byte(input logic [BYTE_W-1:0] b, input bit typed,
                             input bit typed_gives, input result_t typed_res);
        result_t res;
        bit      gives;
        @(negedge aclk);
        while (!steady_flow && $urandom_range(99) < 19) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_stream_byte <= b;
        do @(posedge aclk); while (!s_ready);
        gives = deframe_byte(b, res);
        if (typed) begin
            if (typed_gives) begin
                due_add(typed_res);
            end
        end else if (gives) begin
            due_add(res);
        end
    endtask

    // Stops the sender and lets every due result and any prefix byte in flight drain.
    task automatic settle_block();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_MIN_OCTETS) begin
            lim_min = val;
        end else begin
            lim_max = val;
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_prefix(input logic [LEN_W-1:0] len);
        logic [31:0] wide;
        wide = 32'(len);
        for (int k = PREFIX_BYTES - 1; k >= 0; k--) begin
            push_byte(8'(wide >> (8 * k)), 1'b0, 1'b0, '0);
        end
    endtask

    task automatic send_message(input logic [LEN_W-1:0] len);
        send_prefix(len);
        repeat (len) push_byte(8'($urandom), 1'b0, 1'b0, '0);
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("length_prefix_deframer_core_test failed");
        $finish;
    end

    initial begin
        int               rand_items;
        int               phase_items;
        int               phase_no;
        int               hi_len;
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] lo;
        logic [LEN_W-1:0] bad_len;

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                settle_block();
                write_reg(directed_rows[i].index, directed_rows[i].data);
            end else begin
                push_byte(directed_rows[i].data[BYTE_W-1:0], directed_rows[i].typed,
                          directed_rows[i].gives, directed_rows[i].want);
            end
        end

        rand_items = 0;
        phase_no = 0;
        while (rand_items < RANDOM_ITEMS) begin
            settle_block();
            steady_flow = 1'b0;
            case (phase_no % 5)
                0: begin
                    write_reg(REG_MIN_OCTETS, 16'd0);
                    write_reg(REG_MAX_OCTETS, 16'hFFFF);
                end
                1: begin
                    write_reg(REG_MIN_OCTETS, 16'd1);
                    write_reg(REG_MAX_OCTETS, 16'd1);
                end
                2: begin
                    // Only empty messages fit, so this phase gives no results.
                    write_reg(REG_MIN_OCTETS, 16'd0);
                    write_reg(REG_MAX_OCTETS, 16'd0);
                end
                3: begin
                    lo = 16'($urandom_range(20, 0));
                    write_reg(REG_MIN_OCTETS, lo);
                    write_reg(REG_MAX_OCTETS, lo + 16'($urandom_range(40, 0)));
                    steady_flow = 1'b1;
                end
                default: begin
                    write_reg(REG_MIN_OCTETS, 16'd12);
                    write_reg(REG_MAX_OCTETS, 16'd300);
                end
            endcase
            phase_items = 0;
            while (phase_items < PHASE_ITEMS && rand_items < RANDOM_ITEMS) begin
                if (lim_max >= 256 && $urandom_range(29, 0) == 0) begin
                    hi_len = (lim_max < 320) ? int'(lim_max) : 320;
                    len = 16'($urandom_range(hi_len, 256));
                end else begin
                    hi_len = (int'(lim_max) > int'(lim_min) + 24) ? int'(lim_min) + 24
                                                                  : int'(lim_max);
                    len = 16'($urandom_range(hi_len, int'(lim_min)));
                end
                send_message(len);
                phase_items += int'(len) + PREFIX_BYTES;
                rand_items += int'(len) + PREFIX_BYTES;
                if ($urandom_range(19, 0) == 0) begin
                    settle_block();
                end
            end
            phase_no++;
        end

        // The malformed-length report is sticky, so it closes the run.
        settle_block();
        steady_flow = 1'b0;
        case ($urandom_range(2, 0))
            0: begin
                write_reg(REG_MIN_OCTETS, 16'hFFFF);
                write_reg(REG_MAX_OCTETS, 16'hFFFF);
                bad_len = 16'hFFFE;
            end
            1: begin
                write_reg(REG_MIN_OCTETS, 16'd0);
                write_reg(REG_MAX_OCTETS, 16'd0);
                bad_len = 16'd1;
            end
            default: begin
                // Minimum above maximum rejects every length.
                write_reg(REG_MIN_OCTETS, 16'd500);
                write_reg(REG_MAX_OCTETS, 16'd100);
                bad_len = 16'd300;
            end
        endcase
        send_prefix(bad_len);
        repeat (8) push_byte(8'($urandom), 1'b0, 1'b0, '0);
        settle_block();
        // Limits written after the failure are stored but revive nothing.
        write_reg(REG_MIN_OCTETS, 16'd0);
        write_reg(REG_MAX_OCTETS, 16'hFFFF);
        send_message(16'd3);
        settle_block();

        if (bad_count == 0 && due_results.size() == 0) begin
            $display("length_prefix_deframer_core_test passed");
        end else begin
            $display("length_prefix_deframer_core_test failed");
        end
        $finish;
    end

endmodule
